>>> sv/ttmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttmc_pkg
// Shared types, sizes and helper functions of the touch trimmed-mean
// calibration block.
// ----------------------------------------------------------------------------
package ttmc_pkg;

  localparam int SAMPLES_PER_POINT = 5;
  localparam int SAMPLE_BITS       = 12;

  localparam int CNT_W   = $clog2(SAMPLES_PER_POINT);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(SAMPLES_PER_POINT);
  localparam int TRIM_DIV = SAMPLES_PER_POINT - 2;

  // Division by the trim divisor as a multiply by a rounded-up reciprocal.
  // The shift of SUM_W plus ceil(log2(divisor)) keeps the quotient exact
  // over the whole range of the trimmed sum.
  localparam int DIV_SH  = SUM_W + $clog2(TRIM_DIV);
  localparam int RECIP_W = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV));
  localparam int DIVP_W  = SUM_W + RECIP_W;

  localparam int CFG_W    = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int PROD_W   = CFG_W + SAMPLE_BITS + 1;
  localparam int MAP_W    = PROD_W + 1;
  localparam int COORD_W  = 16;

  localparam logic [COORD_W-1:0] NEAR_LIMIT  = COORD_W'(8);
  localparam logic [COORD_W-1:0] REJECT_CODE = COORD_W'(12'hfff);

  localparam logic signed [CFG_W-1:0] GAIN_RESET   = CFG_W'(65536);
  localparam logic signed [CFG_W-1:0] OFFSET_RESET = '0;

  // Register indexes (word address bits of the configuration port).
  localparam logic [1:0] REG_GAIN_X   = 2'd0;
  localparam logic [1:0] REG_OFFSET_X = 2'd1;
  localparam logic [1:0] REG_GAIN_Y   = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_x;
    logic [SAMPLE_BITS-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
    logic               rejected;
  } coord_t;

  function automatic logic [SAMPLE_BITS-1:0] div_trim(input logic [SUM_W-1:0] n);
    logic [DIVP_W-1:0] p;
    p = DIVP_W'(n) * DIVP_W'(RECIP);
    return p[DIV_SH +: SAMPLE_BITS];
  endfunction

  // Adds the offset, drops the fraction and clamps to the screen range.
  function automatic logic [COORD_W-1:0] clamp_point(input logic signed [PROD_W-1:0] p,
                                                     input logic signed [CFG_W-1:0] off);
    logic signed [MAP_W-1:0] v;
    v = MAP_W'(p) + MAP_W'(off);
    if (v[MAP_W-1]) begin
      return '0;
    end else if (|v[MAP_W-2:32]) begin
      return '1;
    end
    return v[31:16];
  endfunction

endpackage

>>> sv/touch_trimmed_mean_calibrate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_trimmed_mean_calibrate_core
// Trimmed-mean touch filter with per-axis linear calibration and a
// two-point agreement check.
// ----------------------------------------------------------------------------
// The block takes one raw (x, y) sample transaction per clock cycle. Every
// five samples form a smoothed point (sum less minimum and maximum, divided
// by three), which is mapped through the signed Q16.16 gain and offset of
// each axis and clamped to 0..65535; every second point yields one
// coordinate transaction, so one result follows every ten samples. The
// result passes through registers for the trimmed sum, the quotient, the
// gain product, the mapped point and the output. Samples stall only when
// the output is stalled and a finished group would otherwise overrun the
// points already in flight. Configuration writes are meant for idle
// periods; registers lie at byte addresses 0, 4, 8 and 12 (gain_x,
// offset_x, gain_y, offset_y).
module touch_trimmed_mean_calibrate_core import ttmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  coord_valid,
  input  logic                  coord_stall,
  output coord_t                coord,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]      pwdata,
  output logic [CFG_W-1:0]      prdata,
  output logic                  pready
);

  logic signed [CFG_W-1:0] gain_x, offset_x, gain_y, offset_y;
  logic [1:0]              reg_idx;
  logic                    cfg_write, take;
  logic                    mean_valid, mean_ready, pt_valid, pt_ready;
  logic [SAMPLE_BITS-1:0]  mean_x, mean_y;
  logic [COORD_W-1:0]      pt_x, pt_y;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign take      = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x   <= GAIN_RESET;
      offset_x <= OFFSET_RESET;
      gain_y   <= GAIN_RESET;
      offset_y <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_GAIN_X:   gain_x   <= pwdata;
        REG_OFFSET_X: offset_x <= pwdata;
        REG_GAIN_Y:   gain_y   <= pwdata;
        REG_OFFSET_Y: offset_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_X:   prdata = gain_x;
      REG_OFFSET_X: prdata = offset_x;
      REG_GAIN_Y:   prdata = gain_y;
      REG_OFFSET_Y: prdata = offset_y;
      default:      prdata = '0;
    endcase
  end

  ttmc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .sample     (sample),
    .block      (sample_stall),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready),
    .mean_x     (mean_x),
    .mean_y     (mean_y)
  );

  ttmc_map u_map (
    .clk        (clk),
    .rst        (rst),
    .mean_valid (mean_valid),
    .mean_ready (mean_ready),
    .mean_x     (mean_x),
    .mean_y     (mean_y),
    .gain_x     (gain_x),
    .offset_x   (offset_x),
    .gain_y     (gain_y),
    .offset_y   (offset_y),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pt_x       (pt_x),
    .pt_y       (pt_y)
  );

  ttmc_pair u_pair (
    .clk         (clk),
    .rst         (rst),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt_x        (pt_x),
    .pt_y        (pt_y),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coord       (coord)
  );

endmodule

>>> sv/ttmc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttmc_accum
// Running sum, minimum and maximum per axis; registers the trimmed sum of
// each finished group and then its quotient by the trim divisor.
// ----------------------------------------------------------------------------
module ttmc_accum import ttmc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  sample_t                sample,
  output logic                   block,
  output logic                   mean_valid,
  input  logic                   mean_ready,
  output logic [SAMPLE_BITS-1:0] mean_x,
  output logic [SAMPLE_BITS-1:0] mean_y
);

  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum_x, sum_y;
  logic [SAMPLE_BITS-1:0] min_x, max_x, min_y, max_y;
  logic                   trim_valid;
  logic [SUM_W-1:0]       trim_x, trim_y;

  logic [SUM_W-1:0]       sum_x_next, sum_y_next;
  logic [SAMPLE_BITS-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic                   is_last, mean_load_ok, trim_move, trim_load_ok;

  always_comb begin
    sum_x_next = sum_x + SUM_W'(sample.raw_x);
    sum_y_next = sum_y + SUM_W'(sample.raw_y);
    min_x_next = (sample.raw_x < min_x) ? sample.raw_x : min_x;
    max_x_next = (sample.raw_x > max_x) ? sample.raw_x : max_x;
    min_y_next = (sample.raw_y < min_y) ? sample.raw_y : min_y;
    max_y_next = (sample.raw_y > max_y) ? sample.raw_y : max_y;
    is_last    = (count == CNT_W'(SAMPLES_PER_POINT - 1));
  end

  assign mean_load_ok = !mean_valid || mean_ready;
  assign trim_move    = trim_valid && mean_load_ok;
  assign trim_load_ok = !trim_valid || trim_move;
  // Only the sample that closes a group needs room downstream.
  assign block        = is_last && !trim_load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      min_x      <= '1;
      max_x      <= '0;
      min_y      <= '1;
      max_y      <= '0;
      trim_valid <= 1'b0;
      mean_valid <= 1'b0;
    end else begin
      if (take) begin
        if (is_last) begin
          count <= '0;
          sum_x <= '0;
          sum_y <= '0;
          min_x <= '1;
          max_x <= '0;
          min_y <= '1;
          max_y <= '0;
        end else begin
          count <= count + CNT_W'(1);
          sum_x <= sum_x_next;
          sum_y <= sum_y_next;
          min_x <= min_x_next;
          max_x <= max_x_next;
          min_y <= min_y_next;
          max_y <= max_y_next;
        end
      end

      if (take && is_last) begin
        trim_valid <= 1'b1;
      end else if (trim_move) begin
        trim_valid <= 1'b0;
      end

      if (trim_move) begin
        mean_valid <= 1'b1;
      end else if (mean_ready) begin
        mean_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_last) begin
      trim_x <= sum_x_next - SUM_W'(min_x_next) - SUM_W'(max_x_next);
      trim_y <= sum_y_next - SUM_W'(min_y_next) - SUM_W'(max_y_next);
    end
    if (trim_move) begin
      mean_x <= div_trim(trim_x);
      mean_y <= div_trim(trim_y);
    end
  end

endmodule

>>> sv/ttmc_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttmc_map
// Maps a smoothed point to screen coordinates: one register stage for the
// gain products, one for offset, truncation and clamping.
// ----------------------------------------------------------------------------
module ttmc_map import ttmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     mean_valid,
  output logic                     mean_ready,
  input  logic [SAMPLE_BITS-1:0]   mean_x,
  input  logic [SAMPLE_BITS-1:0]   mean_y,
  input  logic signed [CFG_W-1:0]  gain_x,
  input  logic signed [CFG_W-1:0]  offset_x,
  input  logic signed [CFG_W-1:0]  gain_y,
  input  logic signed [CFG_W-1:0]  offset_y,
  output logic                     pt_valid,
  input  logic                     pt_ready,
  output logic [COORD_W-1:0]       pt_x,
  output logic [COORD_W-1:0]       pt_y
);

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [SAMPLE_BITS:0] mean_x_s, mean_y_s;
  logic signed [PROD_W-1:0] prod_x_next, prod_y_next;
  logic                     pt_load_ok, prod_move, mean_take;

  assign mean_x_s    = $signed({1'b0, mean_x});
  assign mean_y_s    = $signed({1'b0, mean_y});
  assign prod_x_next = PROD_W'(gain_x) * PROD_W'(mean_x_s);
  assign prod_y_next = PROD_W'(gain_y) * PROD_W'(mean_y_s);

  assign pt_load_ok = !pt_valid || pt_ready;
  assign prod_move  = prod_valid && pt_load_ok;
  assign mean_ready = !prod_valid || prod_move;
  assign mean_take  = mean_valid && mean_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      pt_valid   <= 1'b0;
    end else begin
      if (mean_take) begin
        prod_valid <= 1'b1;
      end else if (prod_move) begin
        prod_valid <= 1'b0;
      end

      if (prod_move) begin
        pt_valid <= 1'b1;
      end else if (pt_ready) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_take) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
    end
    if (prod_move) begin
      pt_x <= clamp_point(prod_x, offset_x);
      pt_y <= clamp_point(prod_y, offset_y);
    end
  end

endmodule

>>> sv/ttmc_pair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttmc_pair
// Holds the first of two mapped points, compares the second against it and
// drives the registered coordinate output.
// ----------------------------------------------------------------------------
module ttmc_pair import ttmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pt_valid,
  output logic               pt_ready,
  input  logic [COORD_W-1:0] pt_x,
  input  logic [COORD_W-1:0] pt_y,
  output logic               coord_valid,
  input  logic               coord_stall,
  output coord_t             coord
);

  logic               phase;
  logic [COORD_W-1:0] first_x, first_y;
  logic [COORD_W-1:0] diff_x, diff_y;
  logic [COORD_W:0]   total_x, total_y;
  logic               take, near;
  coord_t             coord_next;

  // A first point never needs the output, so it is taken even while the
  // output transaction is stalled.
  assign pt_ready = !(phase && coord_valid && coord_stall);
  assign take     = pt_valid && pt_ready;

  always_comb begin
    diff_x  = (first_x > pt_x) ? first_x - pt_x : pt_x - first_x;
    diff_y  = (first_y > pt_y) ? first_y - pt_y : pt_y - first_y;
    near    = (diff_x < NEAR_LIMIT) && (diff_y < NEAR_LIMIT);
    total_x = {1'b0, first_x} + {1'b0, pt_x};
    total_y = {1'b0, first_y} + {1'b0, pt_y};
    if (near) begin
      coord_next.screen_x = total_x[COORD_W:1];
      coord_next.screen_y = total_y[COORD_W:1];
      coord_next.rejected = 1'b0;
    end else begin
      coord_next.screen_x = REJECT_CODE;
      coord_next.screen_y = REJECT_CODE;
      coord_next.rejected = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 1'b0;
      coord_valid <= 1'b0;
      first_x     <= '0;
      first_y     <= '0;
    end else begin
      if (take) begin
        phase <= !phase;
        if (!phase) begin
          first_x <= pt_x;
          first_y <= pt_y;
        end
      end

      if (take && phase) begin
        coord_valid <= 1'b1;
      end else if (!coord_stall) begin
        coord_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase) begin
      coord <= coord_next;
    end
  end

endmodule

>>> sv/ttmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttmc_checker
// Port-level checks of the touch calibration block, bound to the top level.
// ----------------------------------------------------------------------------
module ttmc_checker import ttmc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   sample_stall,
  input logic   coord_valid,
  input logic   coord_stall,
  input coord_t coord
);

  // A stalled coordinate transaction holds its valid and its payload.
  a_coord_hold: assert property (@(posedge clk) disable iff (rst)
    coord_valid && coord_stall |=> coord_valid && $stable(coord))
    else $error("coordinate changed while stalled");

  // A rejected pair always carries the reject code on both axes.
  a_reject_code: assert property (@(posedge clk) disable iff (rst)
    coord_valid && coord.rejected |->
      coord.screen_x == REJECT_CODE && coord.screen_y == REJECT_CODE)
    else $error("rejected result without reject code");

  // Input back-pressure only ever comes from a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> coord_valid && coord_stall)
    else $error("sample stalled while output is free");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !coord_valid)
    else $error("result valid after reset");

endmodule

bind touch_trimmed_mean_calibrate_core ttmc_checker u_ttmc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .coord_valid  (coord_valid),
  .coord_stall  (coord_stall),
  .coord        (coord)
);

>>> tb/touch_trimmed_mean_calibrate_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_trimmed_mean_calibrate_core_test
// Self-checking testbench for the trimmed-mean touch calibration core.
// ----------------------------------------------------------------------------
// Raw sample transactions go in with random gaps and coordinate transactions
// come out against random stalls. A behavioral copy of the filter computes
// every coordinate the core should produce and queues it. Each coordinate
// that leaves the core is checked field by field against the oldest entry.
// Directed points cover the sample extremes, the clamps at both ends, pair
// rejection, trimming of outliers and rounding of the pair mean. Random
// phases follow, each under new calibration registers.
module touch_trimmed_mean_calibrate_core_test;
  import ttmc_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_SAMPLE    = (1 << SAMPLE_BITS) - 1;

  typedef logic [SAMPLE_BITS-1:0] five_t [SAMPLES_PER_POINT];

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  sample_t               sample       = '0;
  logic                  coord_stall  = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [CFG_W-1:0]      pwdata       = '0;
  logic                  sample_stall;
  logic                  coord_valid;
  coord_t                coord;
  logic [CFG_W-1:0]      prdata;
  logic                  pready;

  touch_trimmed_mean_calibrate_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .coord_valid  (coord_valid),
    .coord_stall  (coord_stall),
    .coord        (coord),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Calibration registers and filter state as the core should hold them.
  logic signed [CFG_W-1:0] cal_gain_x;
  logic signed [CFG_W-1:0] cal_offset_x;
  logic signed [CFG_W-1:0] cal_gain_y;
  logic signed [CFG_W-1:0] cal_offset_y;
  logic [SUM_W-1:0]        acc_sum_x;
  logic [SUM_W-1:0]        acc_sum_y;
  logic [SAMPLE_BITS-1:0]  acc_min_x;
  logic [SAMPLE_BITS-1:0]  acc_max_x;
  logic [SAMPLE_BITS-1:0]  acc_min_y;
  logic [SAMPLE_BITS-1:0]  acc_max_y;
  logic [CNT_W-1:0]        acc_count;
  logic                    point_waiting;
  logic [COORD_W-1:0]      held_x;
  logic [COORD_W-1:0]      held_y;

  coord_t expected_coords[$];
  coord_t want;
  int     mismatch_count = 0;
  bit     steady_sender  = 1'b0;
  int     stall_left     = 0;
  int     calm_left      = 0;
  int     roll;

  task automatic clear_accumulators();
    acc_sum_x = '0;
    acc_sum_y = '0;
    acc_min_x = '1;
    acc_max_x = '0;
    acc_min_y = '1;
    acc_max_y = '0;
    acc_count = '0;
  endtask

  function automatic logic [COORD_W-1:0] calibrate_axis(input logic [SAMPLE_BITS-1:0] mean,
                                                        input logic signed [CFG_W-1:0] gain,
                                                        input logic signed [CFG_W-1:0] offset);
    longint v;
    v = longint'(gain) * longint'(mean) + longint'(offset);
    if (v < 0) begin
      return '0;
    end else if ((v >>> 16) > 65535) begin
      return '1;
    end
    return v[31:16];
  endfunction

  function automatic bit within_limit(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    return ((a > b) ? (a - b) : (b - a)) < NEAR_LIMIT;
  endfunction

  task automatic accumulate_sample(input sample_t s);
    logic [SAMPLE_BITS-1:0] mean_x;
    logic [SAMPLE_BITS-1:0] mean_y;
    logic [COORD_W-1:0]     pt_x;
    logic [COORD_W-1:0]     pt_y;
    coord_t                 res;
    acc_sum_x = acc_sum_x + SUM_W'(s.raw_x);
    acc_sum_y = acc_sum_y + SUM_W'(s.raw_y);
    if (s.raw_x < acc_min_x) acc_min_x = s.raw_x;
    if (s.raw_x > acc_max_x) acc_max_x = s.raw_x;
    if (s.raw_y < acc_min_y) acc_min_y = s.raw_y;
    if (s.raw_y > acc_max_y) acc_max_y = s.raw_y;
    acc_count = acc_count + 1'b1;
    if (acc_count == CNT_W'(SAMPLES_PER_POINT)) begin
      mean_x = SAMPLE_BITS'((acc_sum_x - SUM_W'(acc_min_x) - SUM_W'(acc_max_x))
                            / SUM_W'(TRIM_DIV));
      mean_y = SAMPLE_BITS'((acc_sum_y - SUM_W'(acc_min_y) - SUM_W'(acc_max_y))
                            / SUM_W'(TRIM_DIV));
      clear_accumulators();
      pt_x = calibrate_axis(mean_x, cal_gain_x, cal_offset_x);
      pt_y = calibrate_axis(mean_y, cal_gain_y, cal_offset_y);
      if (!point_waiting) begin
        held_x        = pt_x;
        held_y        = pt_y;
        point_waiting = 1'b1;
      end else begin
        point_waiting = 1'b0;
        if (within_limit(held_x, pt_x) && within_limit(held_y, pt_y)) begin
          res.screen_x = COORD_W'(({1'b0, held_x} + {1'b0, pt_x}) >> 1);
          res.screen_y = COORD_W'(({1'b0, held_y} + {1'b0, pt_y}) >> 1);
          res.rejected = 1'b0;
        end else begin
          res.screen_x = REJECT_CODE;
          res.screen_y = REJECT_CODE;
          res.rejected = 1'b1;
        end
        expected_coords.push_back(res);
      end
    end
  endtask

  // Coordinate side: check every accepted transaction and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      coord_stall <= 1'b0;
    end else begin
      if (coord_valid && !coord_stall) begin
        if (expected_coords.size() == 0) begin
          $error("coord transaction with nothing expected: x %0d y %0d rejected %0d",
                 coord.screen_x, coord.screen_y, coord.rejected);
          mismatch_count++;
        end else begin
          want = expected_coords.pop_front();
          if (coord.screen_x !== want.screen_x) begin
            $error("screen_x expected %0d actual %0d", want.screen_x, coord.screen_x);
            mismatch_count++;
          end
          if (coord.screen_y !== want.screen_y) begin
            $error("screen_y expected %0d actual %0d", want.screen_y, coord.screen_y);
            mismatch_count++;
          end
          if (coord.rejected !== want.rejected) begin
            $error("rejected expected %0d actual %0d", want.rejected, coord.rejected);
            mismatch_count++;
          end
        end
      end
      if (calm_left > 0) begin
        calm_left--;
        coord_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        coord_stall <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          calm_left = $urandom_range(50, 150);
        end else if (roll < 15) begin
          stall_left = $urandom_range(1, 3);
        end else if (roll < 17) begin
          stall_left = $urandom_range(10, 40);
        end
        coord_stall <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the sample.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    accumulate_sample(s);
  endtask

  // Stop sending, let every expected coordinate drain and give the pipeline
  // time to finish a first point that produces no transaction of its own.
  task automatic settle_block();
    sample_valid <= 1'b0;
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the bus idle after the access phase before it returns, so
  // back-to-back writes each start from an idle bus.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_X:   cal_gain_x   = value;
      REG_OFFSET_X: cal_offset_x = value;
      REG_GAIN_Y:   cal_gain_y   = value;
      REG_OFFSET_Y: cal_offset_y = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_five(input five_t xs, input five_t ys);
    sample_t s;
    for (int i = 0; i < SAMPLES_PER_POINT; i++) begin
      s.raw_x = xs[i];
      s.raw_y = ys[i];
      send_sample(s);
    end
  endtask

  function automatic logic [SAMPLE_BITS-1:0] jitter(input int base, input int spread);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > MAX_SAMPLE) v = MAX_SAMPLE;
    return SAMPLE_BITS'(v);
  endfunction

  // A tidy point holds near its base with at most one wild sample in it.
  task automatic send_point(input bit tidy, input int bx, input int by);
    int      wild;
    sample_t s;
    wild = $urandom_range(0, 6);
    for (int i = 0; i < SAMPLES_PER_POINT; i++) begin
      if (!tidy || i == wild) begin
        s.raw_x = SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE));
        s.raw_y = SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE));
      end else begin
        s.raw_x = jitter(bx, 2);
        s.raw_y = jitter(by, 2);
      end
      send_sample(s);
    end
  endtask

  function automatic int pick_base();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? MAX_SAMPLE : 0;
    return $urandom_range(0, MAX_SAMPLE);
  endfunction

  task automatic send_pair();
    int bx;
    int by;
    bit tidy;
    bx            = pick_base();
    by            = pick_base();
    tidy          = $urandom_range(0, 4) != 0;
    steady_sender = $urandom_range(0, 5) == 0;
    send_point(tidy, bx, by);
    send_point(tidy, bx + int'($urandom_range(0, 6)) - 3, by + int'($urandom_range(0, 6)) - 3);
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return CFG_W'($urandom_range(0, 4 << 16));
      6:       return CFG_W'(-int'($urandom_range(0, 4 << 16)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:             return 32'h7fff_ffff;
      1:             return 32'h8000_0000;
      2:             return '0;
      3, 4, 5, 6:    return CFG_W'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
      default:       return $urandom;
    endcase
  endfunction

  // Reset calibration: an all-zero point against a full-scale point is rejected.
  task automatic test_reset_defaults();
    send_five('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0});
    send_five('{4095, 4095, 4095, 4095, 4095}, '{4095, 4095, 4095, 4095, 4095});
    settle_block();
  endtask

  // Largest gain and offset clamp x high; most negative ones clamp y to zero.
  task automatic test_clamp_extremes();
    write_reg(REG_GAIN_X, 32'h7fff_ffff);
    write_reg(REG_OFFSET_X, 32'h7fff_ffff);
    write_reg(REG_GAIN_Y, 32'h8000_0000);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    send_five('{4095, 1, 2048, 3000, 77}, '{77, 3000, 2048, 1, 4095});
    send_five('{10, 4095, 900, 4000, 3}, '{0, 4095, 0, 4095, 2});
    settle_block();
  endtask

  // Outliers are trimmed away and the pair mean rounds down.
  task automatic test_trim_and_rounding();
    write_reg(REG_GAIN_X, GAIN_RESET);
    write_reg(REG_OFFSET_X, OFFSET_RESET);
    write_reg(REG_GAIN_Y, GAIN_RESET);
    write_reg(REG_OFFSET_Y, 32'h0000_8000);
    send_five('{100, 100, 100, 0, 4095}, '{200, 4095, 200, 200, 0});
    send_five('{103, 4095, 103, 103, 0}, '{0, 205, 205, 4095, 205});
    settle_block();
  endtask

  task automatic test_random_traffic();
    sample_t s;
    for (int phase = 0; phase < 8; phase++) begin
      settle_block();
      write_reg(REG_GAIN_X, pick_gain());
      write_reg(REG_OFFSET_X, pick_offset());
      write_reg(REG_GAIN_Y, pick_gain());
      write_reg(REG_OFFSET_Y, pick_offset());
      for (int n = 0; n < 12; n++) begin
        // A lone sample now and then shifts the grouping against the pairs.
        if ($urandom_range(0, 19) == 0) begin
          s.raw_x = SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE));
          s.raw_y = SAMPLE_BITS'($urandom_range(0, MAX_SAMPLE));
          send_sample(s);
        end
        send_pair();
      end
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    cal_gain_x    = GAIN_RESET;
    cal_offset_x  = OFFSET_RESET;
    cal_gain_y    = GAIN_RESET;
    cal_offset_y  = OFFSET_RESET;
    point_waiting = 1'b0;
    held_x        = '0;
    held_y        = '0;
    clear_accumulators();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_clamp_extremes();
    test_trim_and_rounding();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0 && expected_coords.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ttmc_pkg.sv
sv/ttmc_accum.sv
sv/ttmc_map.sv
sv/ttmc_pair.sv
sv/touch_trimmed_mean_calibrate_core.sv
sv/ttmc_checker.sv
tb/touch_trimmed_mean_calibrate_core_test.sv
